@@ hw/rtl/kth_pkg.sv @@
// Shared types, constants and lookup tables for the katakana to hiragana stream.
`timescale 1ns / 1ps

package kth_pkg;

    // Source position saturates at this count.
    localparam int unsigned MAX_SOURCE_LENGTH = 4096;
    localparam int unsigned POS_W = 13;

    // Code points that steer the conversion.
    localparam logic [15:0] FW_KATA_FIRST   = 16'h30A1;
    localparam logic [15:0] FW_KATA_LAST    = 16'h30F6;
    localparam logic [15:0] KATA_SHIFT      = 16'h0060;
    localparam logic [15:0] FW_LONG_MARK    = 16'h30FC;
    localparam logic [15:0] HW_LONG_MARK    = 16'hFF70;
    localparam logic [15:0] HW_KATA_FIRST   = 16'hFF66;
    localparam logic [15:0] HW_KATA_LAST    = 16'hFF9D;
    localparam logic [15:0] HW_VOICED_MARK  = 16'hFF9E;
    localparam logic [15:0] HW_SEMI_MARK    = 16'hFF9F;
    localparam logic [15:0] LONG_PREV_FIRST = 16'h3041;
    localparam logic [15:0] LONG_PREV_LAST  = 16'h3094;
    localparam logic [15:0] VOICED_FIRST    = 16'h3046;
    localparam logic [15:0] VOICED_LAST     = 16'h307B;
    localparam logic [15:0] SEMI_FIRST      = 16'h306F;
    localparam logic [15:0] SEMI_LAST       = 16'h307B;

    localparam logic [15:0] HV_A = 16'h3042;
    localparam logic [15:0] HV_I = 16'h3044;
    localparam logic [15:0] HV_U = 16'h3046;
    localparam logic [15:0] HV_L = 16'h30FC;

    // Half-width katakana, indexed by unit - 0xFF66.
    localparam logic [15:0] HALF_WIDTH_TAB [56] = '{
        16'h3092,
        16'h3041, 16'h3043, 16'h3045, 16'h3047, 16'h3049,
        16'h3083, 16'h3085, 16'h3087,
        16'h3063, 16'h30FC,
        16'h3042, 16'h3044, 16'h3046, 16'h3048, 16'h304A,
        16'h304B, 16'h304D, 16'h304F, 16'h3051, 16'h3053,
        16'h3055, 16'h3057, 16'h3059, 16'h305B, 16'h305D,
        16'h305F, 16'h3061, 16'h3064, 16'h3066, 16'h3068,
        16'h306A, 16'h306B, 16'h306C, 16'h306D, 16'h306E,
        16'h306F, 16'h3072, 16'h3075, 16'h3078, 16'h307B,
        16'h307E, 16'h307F, 16'h3080, 16'h3081, 16'h3082,
        16'h3084, 16'h3086, 16'h3088,
        16'h3089, 16'h308A, 16'h308B, 16'h308C, 16'h308D,
        16'h308F, 16'h3093
    };

    // Voiced forms, indexed by previous - 0x3046.
    localparam logic [15:0] VOICED_TAB [54] = '{
        16'h3094, 16'h3047, 16'h3048, 16'h3049, 16'h304A,
        16'h304C, 16'h304C, 16'h304E, 16'h304E, 16'h3050, 16'h3050, 16'h3052,
        16'h3052, 16'h3054, 16'h3054,
        16'h3056, 16'h3056, 16'h3058, 16'h3058, 16'h305A, 16'h305A, 16'h305C,
        16'h305C, 16'h305E, 16'h305E,
        16'h3060, 16'h3060, 16'h3062, 16'h3062,
        16'h3063, 16'h3065, 16'h3065,
        16'h3067, 16'h3067, 16'h3069, 16'h3069,
        16'h306A, 16'h306B, 16'h306C, 16'h306D, 16'h306E,
        16'h3070, 16'h3070, 16'h3071, 16'h3073, 16'h3073, 16'h3074,
        16'h3076, 16'h3076, 16'h3077, 16'h3079, 16'h3079, 16'h307A,
        16'h307C
    };

    // Half-voiced forms, indexed by previous - 0x306F.
    localparam logic [15:0] SEMI_VOICED_TAB [13] = '{
        16'h3071, 16'h3070, 16'h3071, 16'h3074, 16'h3073, 16'h3074,
        16'h3077, 16'h3076, 16'h3077, 16'h307A, 16'h3079, 16'h307A,
        16'h307D
    };

    // Vowel that a long vowel mark stands for, indexed by previous - 0x3041.
    localparam logic [15:0] LONG_VOWEL_TAB [84] = '{
        HV_L, HV_A, HV_L, HV_I, HV_L, HV_U, HV_L, HV_I, HV_L, HV_U,
        HV_A, HV_A, HV_I, HV_I, HV_U, HV_U, HV_I, HV_I, HV_U, HV_U,
        HV_A, HV_A, HV_I, HV_I, HV_U, HV_U, HV_I, HV_I, HV_U, HV_U,
        HV_A, HV_A, HV_I, HV_I, HV_L, HV_U, HV_U, HV_I, HV_I, HV_U, HV_U,
        HV_A, HV_I, HV_U, HV_I, HV_U,
        HV_A, HV_A, HV_A, HV_I, HV_I, HV_I, HV_U, HV_U, HV_U,
        HV_I, HV_I, HV_I, HV_U, HV_U, HV_U,
        HV_A, HV_I, HV_U, HV_I, HV_U,
        HV_A, HV_A, HV_U, HV_U, HV_U, HV_U,
        HV_A, HV_I, HV_U, HV_I, HV_U,
        HV_L, HV_A, HV_I, HV_I, HV_L,
        HV_L, HV_L
    };

    // One input item.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        last_unit;
    } kth_in_t;

    // One result item.
    typedef struct packed {
        logic [15:0]      out_char;
        logic             replace_previous;
        logic [POS_W-1:0] source_end;
        logic             end_of_string;
    } kth_out_t;

    // Conversion of one unit against the previous converted character.
    typedef struct packed {
        logic [15:0] conv_char;
        logic        replace;
    } kth_conv_t;

endpackage

@@ hw/rtl/katakana_to_hiragana_stream.sv @@
// Top level of the katakana to hiragana stream converter.
`timescale 1ns / 1ps

// Usage:
// The unit channel (unit_valid, unit_stall, unit_item) takes one UTF-16 code
// unit per item with a flag that marks the last unit of a string. The result
// channel (result_valid, result_stall, result_item) returns exactly one item
// per unit: the converted character, a flag that says it overwrites the
// previous output, the source end position and the end of string flag.
// An accepted unit lands in the input register and its result is loaded into
// the result register when that register is empty or being taken, which
// raises result_valid. One unit per cycle is sustained while the result
// side does not stall, bounded by the loop through the previous-character
// register, which is updated as each unit converts.
// A stall on the result side holds the result register; the input register
// then keeps its unit and unit_stall rises until the result is taken.
// Reset empties both registers and clears the previous character and the
// position count. Both also clear after a unit marked last.

module katakana_to_hiragana_stream (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              unit_valid,
    output logic              unit_stall,
    input  kth_pkg::kth_in_t  unit_item,
    output logic              result_valid,
    input  logic              result_stall,
    output kth_pkg::kth_out_t result_item
);

    logic              in_valid_reg;
    logic              in_valid_next;
    kth_pkg::kth_in_t  in_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    kth_pkg::kth_out_t out_item_reg;
    kth_pkg::kth_out_t conv_result;
    logic              out_ready;
    logic              advance;
    logic              in_accept;

    // Handshake between the two register stages.
    assign out_ready  = !out_valid_reg || !result_stall;
    assign advance    = in_valid_reg && out_ready;
    assign unit_stall = in_valid_reg && !out_ready;
    assign in_accept  = unit_valid && !unit_stall;

    assign in_valid_next  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (result_stall ? out_valid_reg : 1'b0);

    kth_context u_context (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .result  (conv_result)
    );

    // Valid flags of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_item_reg <= unit_item;
        end
        if (advance)
        begin
            out_item_reg <= conv_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_item_reg;

endmodule

@@ hw/rtl/kth_convert.sv @@
// Combinational conversion of one code unit given the previous converted character.
`timescale 1ns / 1ps

module kth_convert (
    input  logic [15:0]        code_unit,
    input  logic [15:0]        prev_char,
    output kth_pkg::kth_conv_t conv
);

    logic [15:0] hw_off;
    logic [15:0] long_off;
    logic [15:0] voiced_off;
    logic [15:0] semi_off;
    logic        prev_in_long;
    logic        prev_in_voiced;
    logic        prev_in_semi;

    // Table offsets and range checks on the previous character.
    assign hw_off     = code_unit - kth_pkg::HW_KATA_FIRST;
    assign long_off   = prev_char - kth_pkg::LONG_PREV_FIRST;
    assign voiced_off = prev_char - kth_pkg::VOICED_FIRST;
    assign semi_off   = prev_char - kth_pkg::SEMI_FIRST;

    assign prev_in_long   = (prev_char >= kth_pkg::LONG_PREV_FIRST)
                          && (prev_char <= kth_pkg::LONG_PREV_LAST);
    assign prev_in_voiced = (prev_char >= kth_pkg::VOICED_FIRST)
                          && (prev_char <= kth_pkg::VOICED_LAST);
    assign prev_in_semi   = (prev_char >= kth_pkg::SEMI_FIRST)
                          && (prev_char <= kth_pkg::SEMI_LAST);

    // The long vowel check comes before the half-width range, which contains its half-width form.
    always_comb
    begin
        conv.conv_char = code_unit;
        conv.replace   = 1'b0;
        priority if ((code_unit >= kth_pkg::FW_KATA_FIRST)
                     && (code_unit <= kth_pkg::FW_KATA_LAST))
        begin
            conv.conv_char = code_unit - kth_pkg::KATA_SHIFT;
        end
        else if ((code_unit == kth_pkg::FW_LONG_MARK)
                 || (code_unit == kth_pkg::HW_LONG_MARK))
        begin
            if (prev_in_long)
            begin
                conv.conv_char = kth_pkg::LONG_VOWEL_TAB[long_off[6:0]];
            end
        end
        else if ((code_unit >= kth_pkg::HW_KATA_FIRST)
                 && (code_unit <= kth_pkg::HW_KATA_LAST))
        begin
            conv.conv_char = kth_pkg::HALF_WIDTH_TAB[hw_off[5:0]];
        end
        else if (code_unit == kth_pkg::HW_VOICED_MARK)
        begin
            if (prev_in_voiced)
            begin
                conv.conv_char = kth_pkg::VOICED_TAB[voiced_off[5:0]];
                conv.replace   = 1'b1;
            end
        end
        else if (code_unit == kth_pkg::HW_SEMI_MARK)
        begin
            if (prev_in_semi)
            begin
                conv.conv_char = kth_pkg::SEMI_VOICED_TAB[semi_off[3:0]];
                conv.replace   = 1'b1;
            end
        end
        else
        begin
            conv.conv_char = code_unit;
        end
    end

endmodule

@@ hw/rtl/kth_context.sv @@
// String context: previous converted character and source position, plus the result for one item.
`timescale 1ns / 1ps

module kth_context (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  kth_pkg::kth_in_t  item,
    output kth_pkg::kth_out_t result
);

    logic [15:0]               prev_reg;
    logic [15:0]               prev_next;
    logic [kth_pkg::POS_W-1:0] count_reg;
    logic [kth_pkg::POS_W-1:0] count_next;
    logic [kth_pkg::POS_W-1:0] count_sat;
    kth_pkg::kth_conv_t        conv;

    kth_convert u_convert (
        .code_unit (item.code_unit),
        .prev_char (prev_reg),
        .conv      (conv)
    );

    // Position count including this item, held at the maximum.
    localparam logic [kth_pkg::POS_W-1:0] MAX_POS = kth_pkg::POS_W'(kth_pkg::MAX_SOURCE_LENGTH);

    assign count_sat = (count_reg < MAX_POS) ? count_reg + 1'b1 : MAX_POS;

    // The context clears after the last unit of a string.
    assign prev_next  = item.last_unit ? 16'h0000 : conv.conv_char;
    assign count_next = item.last_unit ? '0 : count_sat;

    // Result item for the unit in the input register.
    assign result.out_char         = conv.conv_char;
    assign result.replace_previous = conv.replace;
    assign result.source_end       = count_sat;
    assign result.end_of_string    = item.last_unit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= 16'h0000;
            count_reg <= '0;
        end
        else if (advance)
        begin
            prev_reg  <= prev_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ bench/katakana_to_hiragana_stream_test.sv @@
// Self-checking testbench for the katakana to hiragana stream converter.
`timescale 1ns / 1ps

module katakana_to_hiragana_stream_test;

    // Code points that steer the conversion.
    localparam logic [15:0] CP_KATA_LO    = 16'h30A1;
    localparam logic [15:0] CP_KATA_HI    = 16'h30F6;
    localparam logic [15:0] CP_KATA_SHIFT = 16'h0060;
    localparam logic [15:0] CP_LONG_FULL  = 16'h30FC;
    localparam logic [15:0] CP_LONG_HALF  = 16'hFF70;
    localparam logic [15:0] CP_HALF_LO    = 16'hFF66;
    localparam logic [15:0] CP_HALF_HI    = 16'hFF9D;
    localparam logic [15:0] CP_VOICED     = 16'hFF9E;
    localparam logic [15:0] CP_SEMI       = 16'hFF9F;
    localparam logic [15:0] CP_HIRA_LO    = 16'h3041;
    localparam logic [15:0] CP_HIRA_HI    = 16'h3096;
    localparam logic [15:0] LONG_PREV_LO  = 16'h3041;
    localparam logic [15:0] LONG_PREV_HI  = 16'h3094;
    localparam logic [15:0] VOICED_PREV_LO = 16'h3046;
    localparam logic [15:0] VOICED_PREV_HI = 16'h307B;
    localparam logic [15:0] SEMI_PREV_LO  = 16'h306F;
    localparam logic [15:0] SEMI_PREV_HI  = 16'h307B;

    localparam logic [15:0] LV_A = 16'h3042;
    localparam logic [15:0] LV_I = 16'h3044;
    localparam logic [15:0] LV_U = 16'h3046;
    localparam logic [15:0] LV_L = 16'h30FC;

    // Half-width katakana to hiragana, indexed by unit - 0xFF66.
    localparam logic [15:0] HALF_KANA [56] = '{
        16'h3092,
        16'h3041, 16'h3043, 16'h3045, 16'h3047, 16'h3049,
        16'h3083, 16'h3085, 16'h3087,
        16'h3063, 16'h30FC,
        16'h3042, 16'h3044, 16'h3046, 16'h3048, 16'h304A,
        16'h304B, 16'h304D, 16'h304F, 16'h3051, 16'h3053,
        16'h3055, 16'h3057, 16'h3059, 16'h305B, 16'h305D,
        16'h305F, 16'h3061, 16'h3064, 16'h3066, 16'h3068,
        16'h306A, 16'h306B, 16'h306C, 16'h306D, 16'h306E,
        16'h306F, 16'h3072, 16'h3075, 16'h3078, 16'h307B,
        16'h307E, 16'h307F, 16'h3080, 16'h3081, 16'h3082,
        16'h3084, 16'h3086, 16'h3088,
        16'h3089, 16'h308A, 16'h308B, 16'h308C, 16'h308D,
        16'h308F, 16'h3093
    };

    // Voiced form of the previous character, indexed by previous - 0x3046.
    localparam logic [15:0] VOICED_KANA [54] = '{
        16'h3094, 16'h3047, 16'h3048, 16'h3049, 16'h304A,
        16'h304C, 16'h304C, 16'h304E, 16'h304E, 16'h3050, 16'h3050,
        16'h3052, 16'h3052, 16'h3054, 16'h3054,
        16'h3056, 16'h3056, 16'h3058, 16'h3058, 16'h305A, 16'h305A,
        16'h305C, 16'h305C, 16'h305E, 16'h305E,
        16'h3060, 16'h3060, 16'h3062, 16'h3062,
        16'h3063, 16'h3065, 16'h3065,
        16'h3067, 16'h3067, 16'h3069, 16'h3069,
        16'h306A, 16'h306B, 16'h306C, 16'h306D, 16'h306E,
        16'h3070, 16'h3070, 16'h3071, 16'h3073, 16'h3073, 16'h3074,
        16'h3076, 16'h3076, 16'h3077, 16'h3079, 16'h3079, 16'h307A,
        16'h307C
    };

    // Half-voiced form of the previous character, indexed by previous - 0x306F.
    localparam logic [15:0] SEMI_KANA [13] = '{
        16'h3071, 16'h3070, 16'h3071, 16'h3074, 16'h3073, 16'h3074,
        16'h3077, 16'h3076, 16'h3077, 16'h307A, 16'h3079, 16'h307A,
        16'h307D
    };

    // Vowel that a long vowel mark stands for, indexed by previous - 0x3041.
    localparam logic [15:0] LONG_KANA [84] = '{
        LV_L, LV_A, LV_L, LV_I, LV_L, LV_U, LV_L, LV_I, LV_L, LV_U,
        LV_A, LV_A, LV_I, LV_I, LV_U, LV_U, LV_I, LV_I, LV_U, LV_U,
        LV_A, LV_A, LV_I, LV_I, LV_U, LV_U, LV_I, LV_I, LV_U, LV_U,
        LV_A, LV_A, LV_I, LV_I, LV_L, LV_U, LV_U, LV_I, LV_I, LV_U, LV_U,
        LV_A, LV_I, LV_U, LV_I, LV_U,
        LV_A, LV_A, LV_A, LV_I, LV_I, LV_I, LV_U, LV_U, LV_U,
        LV_I, LV_I, LV_I, LV_U, LV_U, LV_U,
        LV_A, LV_I, LV_U, LV_I, LV_U,
        LV_A, LV_A, LV_U, LV_U, LV_U, LV_U,
        LV_A, LV_I, LV_U, LV_I, LV_U,
        LV_L, LV_A, LV_I, LV_I, LV_L,
        LV_L, LV_L
    };

    localparam int HOLD_OFF_CYCLES   = 200;
    localparam int SETTLE_CYCLES     = 8;
    localparam int WATCHDOG_LIMIT    = 2000;

    // Hand-picked units: boundaries, every mark with and without a fitting
    // previous character, marks at the start of a string, surrogates.
    localparam kth_pkg::kth_in_t DIRECTED_UNITS [25] = '{
        {16'hFF9E, 1'b0}, {16'h30AB, 1'b0}, {16'hFF9E, 1'b0}, {16'h30FC, 1'b0},
        {16'h30CF, 1'b0}, {16'hFF9F, 1'b0}, {16'hFF70, 1'b0}, {16'h3042, 1'b0},
        {16'hFF9F, 1'b0}, {16'h30A1, 1'b0}, {16'h30F6, 1'b0}, {16'h30FC, 1'b0},
        {16'h30A0, 1'b0}, {16'h30F7, 1'b0}, {16'hFF66, 1'b0}, {16'hFF9D, 1'b0},
        {16'hFF65, 1'b0}, {16'hD800, 1'b0}, {16'hDFFF, 1'b0}, {16'h0000, 1'b0},
        {16'hFFFF, 1'b1}, {16'hFF70, 1'b1}, {16'h30F4, 1'b0}, {16'hFF9E, 1'b0},
        {16'h30FC, 1'b1}
    };

    // Predicts each result from the accepted units and checks the results.
    class hiragana_scoreboard;
        logic [15:0]       prev_char;
        logic [12:0]       unit_count;
        kth_pkg::kth_out_t expected_kana [$];
        int                errors;
        int                units_seen;
        int                strings_seen;
        int                overwrites;
        int                saturated;

        function new();
            prev_char    = '0;
            unit_count   = '0;
            errors       = 0;
            units_seen   = 0;
            strings_seen = 0;
            overwrites   = 0;
            saturated    = 0;
        endfunction

        // Bit 16 is the overwrite flag, bits 15..0 the converted character.
        function logic [16:0] to_hiragana(logic [15:0] c, logic [15:0] prev);
            if (c >= CP_KATA_LO && c <= CP_KATA_HI)
                return {1'b0, c - CP_KATA_SHIFT};
            if (c == CP_LONG_FULL || c == CP_LONG_HALF)
            begin
                if (prev >= LONG_PREV_LO && prev <= LONG_PREV_HI)
                    return {1'b0, LONG_KANA[int'(prev - LONG_PREV_LO)]};
                return {1'b0, c};
            end
            if (c >= CP_HALF_LO && c <= CP_HALF_HI)
                return {1'b0, HALF_KANA[int'(c - CP_HALF_LO)]};
            if (c == CP_VOICED)
            begin
                if (prev >= VOICED_PREV_LO && prev <= VOICED_PREV_HI)
                    return {1'b1, VOICED_KANA[int'(prev - VOICED_PREV_LO)]};
                return {1'b0, c};
            end
            if (c == CP_SEMI)
            begin
                if (prev >= SEMI_PREV_LO && prev <= SEMI_PREV_HI)
                    return {1'b1, SEMI_KANA[int'(prev - SEMI_PREV_LO)]};
                return {1'b0, c};
            end
            return {1'b0, c};
        endfunction

        function void note_unit(kth_pkg::kth_in_t u);
            logic [16:0]       conv;
            kth_pkg::kth_out_t r;
            conv = to_hiragana(u.code_unit, prev_char);
            if (unit_count < kth_pkg::MAX_SOURCE_LENGTH)
                unit_count = unit_count + 1'b1;
            else
                saturated++;
            r.out_char         = conv[15:0];
            r.replace_previous = conv[16];
            r.source_end       = unit_count;
            r.end_of_string    = u.last_unit;
            expected_kana.push_back(r);
            units_seen++;
            if (conv[16])
                overwrites++;
            // The string state restarts after the unit marked last.
            prev_char = conv[15:0];
            if (u.last_unit)
            begin
                prev_char  = '0;
                unit_count = '0;
                strings_seen++;
            end
        endfunction

        function void check_result(kth_pkg::kth_out_t got);
            kth_pkg::kth_out_t want;
            if (expected_kana.size() == 0)
            begin
                $error("result with nothing expected: out_char %h", got.out_char);
                errors++;
                return;
            end
            want = expected_kana.pop_front();
            if (got.out_char !== want.out_char)
            begin
                $error("out_char: expected %h, got %h", want.out_char, got.out_char);
                errors++;
            end
            if (got.replace_previous !== want.replace_previous)
            begin
                $error("replace_previous: expected %b, got %b",
                       want.replace_previous, got.replace_previous);
                errors++;
            end
            if (got.source_end !== want.source_end)
            begin
                $error("source_end: expected %0d, got %0d", want.source_end, got.source_end);
                errors++;
            end
            if (got.end_of_string !== want.end_of_string)
            begin
                $error("end_of_string: expected %b, got %b",
                       want.end_of_string, got.end_of_string);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_kana.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n        = 1'b0;
    logic              unit_valid   = 1'b0;
    logic              unit_stall;
    kth_pkg::kth_in_t  unit_item    = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    kth_pkg::kth_out_t result_item;

    hiragana_scoreboard book = new();
    bit quiet        = 1'b0;
    bit hold_off_req = 1'b0;
    int idle_cycles  = 0;

    katakana_to_hiragana_stream dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .unit_valid   (unit_valid),
        .unit_stall   (unit_stall),
        .unit_item    (unit_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // A mix of katakana, marks, hiragana, boundary units and noise.
    function automatic logic [15:0] random_unit();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return 16'($urandom_range(CP_KATA_LO, CP_KATA_HI));
        if (roll < 45)
            return 16'($urandom_range(CP_HALF_LO, CP_HALF_HI));
        if (roll < 65)
        begin
            case ($urandom_range(0, 3))
                0: return CP_VOICED;
                1: return CP_SEMI;
                2: return CP_LONG_FULL;
                default: return CP_LONG_HALF;
            endcase
        end
        if (roll < 75)
            return 16'($urandom_range(CP_HIRA_LO, CP_HIRA_HI));
        if (roll < 80)
        begin
            case ($urandom_range(0, 5))
                0: return CP_KATA_LO - 1'b1;
                1: return CP_KATA_HI + 1'b1;
                2: return CP_HALF_LO - 1'b1;
                3: return CP_SEMI + 1'b1;
                4: return CP_HIRA_LO - 1'b1;
                default: return CP_HIRA_HI + 1'b1;
            endcase
        end
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    // Offers one item at a falling edge and returns at the falling edge after
    // it was taken. Valid stays high between back-to-back items.
    task automatic send_unit(input kth_pkg::kth_in_t u);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            unit_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        unit_item  = u;
        unit_valid = 1'b1;
        @(posedge clk);
        while (unit_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sends whole strings of random length until about count units have gone.
    task automatic send_random_strings(input int count);
        int done;
        int len;
        int roll;
        done = 0;
        while (done < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                len = $urandom_range(1, 12);
            else if (roll < 95)
                len = $urandom_range(13, 60);
            else
                len = $urandom_range(61, 200);
            for (int k = 0; k < len; k++)
                send_unit({random_unit(), k == len - 1});
            done += len;
        end
    endtask

    task automatic wait_for_results();
        while (book.outstanding() != 0)
            @(negedge clk);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_stall = 1'b1;
                stall_left--;
            end
            else
            begin
                result_stall = 1'b0;
                if (hold_off_req)
                begin
                    stall_left   = HOLD_OFF_CYCLES;
                    hold_off_req = 1'b0;
                end
                else if (!quiet)
                    stall_left = pick_gap();
            end
        end
    end

    // Both handshakes are observed here; a long spell without any item
    // moving ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((unit_valid && !unit_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (unit_valid && !unit_stall)
                book.note_unit(unit_item);
            if (result_valid && !result_stall)
                book.check_result(result_item);
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no item moved for %0d cycles.", WATCHDOG_LIMIT);
                $display("FAIL katakana_to_hiragana_stream");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed units first.
        foreach (DIRECTED_UNITS[i])
            send_unit(DIRECTED_UNITS[i]);

        send_random_strings(500);

        // Sender pauses until the block has drained.
        unit_valid = 1'b0;
        wait_for_results();

        // A stretch with no idling on either side.
        quiet = 1'b1;
        send_random_strings(200);

        // The receiver holds off while items keep coming, so the block backs up.
        hold_off_req = 1'b1;
        send_random_strings(60);
        quiet = 1'b0;

        send_random_strings(560);
        unit_valid = 1'b0;

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (book.outstanding() != 0)
        begin
            $error("%0d results never arrived", book.outstanding());
            book.errors++;
        end

        $display("Covered %0d units in %0d strings, %0d overwrite results,",
                 book.units_seen, book.strings_seen, book.overwrites);
        $display("and %0d units past the saturated source position.", book.saturated);
        if (book.errors == 0)
            $display("PASS katakana_to_hiragana_stream");
        else
            $display("FAIL katakana_to_hiragana_stream");
        $finish;
    end

endmodule
